@@ src/audio_echo_tremolo_clip_chain_assert.svh @@
// Assertion macros for the audio effects chain.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef AUDIO_ECHO_TREMOLO_CLIP_CHAIN_ASSERT_SVH
`define AUDIO_ECHO_TREMOLO_CLIP_CHAIN_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ATC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ATC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/atc_pkg.sv @@
// Shared constants, tables, types and helpers for the audio effects chain.
// No dependencies; imported by every module of the block.
package atc_pkg;

  localparam int DELAY_DEPTH = 32768;
  localparam int PHASE_BITS  = 16;

  localparam int AW     = $clog2(DELAY_DEPTH);
  localparam int CNT_W  = AW + 1;
  localparam int LEN_W  = 16;
  localparam int CMP_W  = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
  localparam int PHASE_STEP = ((5 << PHASE_BITS) + 11025) / 22050;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [1:0] REG_DELAY    = 2'd0;
  localparam logic [1:0] REG_DEPTH    = 2'd1;
  localparam logic [1:0] REG_SOFTCLIP = 2'd2;
  localparam logic [1:0] REG_VOLUME   = 2'd3;

  localparam logic [6:0] VOLUME_RESET = 7'd80;
  localparam logic [6:0] PCT_MAX      = 7'd100;

  localparam logic signed [15:0] FEEDBACK_Q15 = 16'sd11469;
  localparam logic signed [15:0] WET_Q15      = 16'sd18022;

  // Reciprocal of 100 scaled by 2^37; exact floor for any 32-bit numerator.
  localparam logic [31:0] RECIP100  = 32'h51EB851F;
  localparam int          RECIP_SH  = 37;
  // Offset that makes the volume numerator positive; a multiple of 100.
  localparam logic [31:0] VOL_BIAS  = 32'd838860800;

  localparam logic [15:0] QSINE [0:16] = '{
    16'd0, 16'd3212, 16'd6393, 16'd9512, 16'd12539, 16'd15446, 16'd18204,
    16'd20787, 16'd23170, 16'd25329, 16'd27245, 16'd28898, 16'd30273,
    16'd31356, 16'd32137, 16'd32609, 16'd32767
  };

  localparam logic [15:0] TANH_TAB [0:16] = '{
    16'd0, 16'd8026, 16'd15143, 16'd20813, 16'd24956, 16'd27797, 16'd29660,
    16'd30847, 16'd31589, 16'd32048, 16'd32329, 16'd32500, 16'd32606,
    16'd32670, 16'd32708, 16'd32732, 16'd32746
  };

  typedef struct packed {
    logic [LEN_W-1:0] delay_len;
    logic [6:0]       depth;
    logic             softclip;
    logic [6:0]       volume;
    logic             wr;
    logic             clr;
  } atc_cfg_t;

  function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
    logic signed [23:0] r;
    if (v > 32'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -32'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  // Round a product by a Q15 factor: floor((p + 2^14) / 2^15).
  function automatic logic signed [31:0] q15_rnd(input logic signed [47:0] p);
    logic signed [47:0] s;
    s = (p + 48'sd16384) >>> 15;
    return s[31:0];
  endfunction

endpackage

@@ src/atc_div100.sv @@
// Floor division of an unsigned 32-bit value by 100 through a reciprocal
// multiply. Depends on atc_pkg; the caller registers the quotient.
module atc_div100 import atc_pkg::*; (
  input  logic [31:0] num_i,
  output logic [26:0] quo_o
);

  logic [63:0] prod;

  assign prod  = 64'(num_i) * 64'(RECIP100);
  assign quo_o = prod[63:RECIP_SH];

endmodule

@@ src/atc_cfg_regs.sv @@
// APB register file for the effects chain settings.
// Depends on atc_pkg; delivers settings and write strobes as one struct.
module atc_cfg_regs import atc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output atc_cfg_t          cfg_o
);

  logic [LEN_W-1:0] delay_len_q, delay_len_d;
  logic [6:0]       depth_q, depth_d;
  logic             softclip_q, softclip_d;
  logic [6:0]       volume_q, volume_d;
  logic             wr;
  logic [1:0]       idx;
  logic [LEN_W-1:0] len_c;
  logic             clr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[3:2];

  // Lengths beyond the store act as the full store.
  assign len_c = ({1'b0, pwdata[LEN_W-1:0]} > (LEN_W+1)'(DELAY_DEPTH)) ?
                 LEN_W'(DELAY_DEPTH) : pwdata[LEN_W-1:0];

  // Only a new nonzero length empties the ring.
  assign clr = wr && (idx == REG_DELAY) && (len_c != '0) && (len_c != delay_len_q);

  always_comb begin
    delay_len_d = delay_len_q;
    depth_d     = depth_q;
    softclip_d  = softclip_q;
    volume_d    = volume_q;
    if (wr) begin
      case (idx)
        REG_DELAY: begin
          if (len_c == '0) begin
            delay_len_d = '0;
          end else begin
            delay_len_d = len_c;
          end
        end
        REG_DEPTH:    depth_d    = pwdata[6:0];
        REG_SOFTCLIP: softclip_d = pwdata[0];
        REG_VOLUME:   volume_d   = pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_len_q <= '0;
      depth_q     <= '0;
      softclip_q  <= 1'b0;
      volume_q    <= VOLUME_RESET;
    end else begin
      delay_len_q <= delay_len_d;
      depth_q     <= depth_d;
      softclip_q  <= softclip_d;
      volume_q    <= volume_d;
    end
  end

  always_comb begin
    case (idx)
      REG_DELAY:    prdata = CFG_DW'(delay_len_q);
      REG_DEPTH:    prdata = CFG_DW'(depth_q);
      REG_SOFTCLIP: prdata = CFG_DW'(softclip_q);
      REG_VOLUME:   prdata = CFG_DW'(volume_q);
      default:      prdata = '0;
    endcase
  end

  assign cfg_o = '{
    delay_len: delay_len_q,
    depth:     depth_q,
    softclip:  softclip_q,
    volume:    volume_q,
    wr:        wr,
    clr:       clr
  };

endmodule

@@ src/atc_echo_store.sv @@
// Echo ring: one synchronous memory with a registered read port, the
// ring position and a fill count. Depends on atc_pkg.
module atc_echo_store import atc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clr_i,
  input  logic [LEN_W-1:0]   delay_len_i,
  input  logic               rd_en_i,
  input  logic               wr_en_i,
  input  logic signed [23:0] wr_data_i,
  output logic signed [23:0] rd_data_o
);

  logic signed [23:0] mem [DELAY_DEPTH];

  logic [AW-1:0]    pos_q, pos_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [AW-1:0]    pos_eff;
  logic [CMP_W-1:0] len_x;
  logic [CMP_W-1:0] pos_inc;
  logic             entry_ok;
  logic signed [23:0] rdata_q;
  logic             rvalid_q;

  assign len_x   = CMP_W'(delay_len_i);
  assign pos_eff = (CMP_W'(pos_q) >= len_x) ? '0 : pos_q;
  assign pos_inc = CMP_W'(pos_eff) + CMP_W'(1);

  // Entries are written in ring order from zero after a clear, so an entry
  // holds data exactly when its index is below the number of writes so far.
  assign entry_ok = CNT_W'(pos_eff) < fill_q;

  always_comb begin
    pos_d  = pos_q;
    fill_d = fill_q;
    if (clr_i) begin
      pos_d  = '0;
      fill_d = '0;
    end else if (wr_en_i) begin
      pos_d = (pos_inc >= len_x) ? '0 : pos_inc[AW-1:0];
      if (fill_q != CNT_W'(DELAY_DEPTH)) begin
        fill_d = fill_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      fill_q   <= '0;
      rvalid_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      fill_q <= fill_d;
      if (rd_en_i) begin
        rvalid_q <= entry_ok;
      end
    end
  end

  // The write back to an entry lands before the next item issues its read,
  // so a one-sample ring still sees its own update.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem[pos_eff];
    end
    if (wr_en_i) begin
      mem[pos_eff] <= wr_data_i;
    end
  end

  assign rd_data_o = rvalid_q ? rdata_q : '0;

endmodule

@@ src/audio_echo_tremolo_clip_chain.sv @@
// Top level of the audio effects chain: sequencer, tremolo oscillator and
// datapath. Depends on atc_pkg, atc_cfg_regs, atc_echo_store, atc_div100 and the assert header.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+-------------------
//   input    | in        | in_valid_i/in_stall_o | sample_in_i  (24)
//   output   | out       | out_valid_o/out_stall_i| sample_out_o (24)
//   config   | in        | APB psel/penable      | paddr/pwdata/prdata
//
// An item is accepted in the idle step and passes the read, mix, write-back, tremolo,
// clip, volume and output steps: one ring read and one write back with echo on, and two passes
// through a shared divide-by-100 multiplier; input stalls until the output step is left.
// A result held by out_stall_i keeps the sequencer in its last step.
// Reset clears control state and the ring's fill count; unwritten entries read as zero.
module audio_echo_tremolo_clip_chain import atc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [23:0] sample_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [23:0] sample_out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [CFG_DW-1:0]  pwdata,
  output logic [CFG_DW-1:0]  prdata,
  output logic               pready
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_MIX  = 3'd2;
  localparam logic [2:0] ST_WB   = 3'd3;
  localparam logic [2:0] ST_TREM = 3'd4;
  localparam logic [2:0] ST_CLIP = 3'd5;
  localparam logic [2:0] ST_VOL  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  atc_cfg_t cfg;

  logic [2:0] state_q, state_d;
  logic       in_acc;
  logic       out_free;
  logic       echo_on;
  logic       trem_on;
  logic [6:0] depth_c;
  logic [6:0] vol_c;

  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [PHASE_BITS+15:0] phase_w;
  logic [15:0] p16;
  logic [1:0]  quad;
  logic [3:0]  seg;
  logic [4:0]  idx_a, idx_b;
  logic [15:0] sa, sb;
  logic signed [16:0] sdiff;
  logic signed [27:0] sprod_d;

  logic signed [23:0] x_q;
  logic [15:0]        sa_q;
  logic signed [27:0] sprod_q;
  logic               sneg_q;
  logic signed [39:0] fbp_q, wetp_q;
  logic [22:0]        dnum_q;
  logic [15:0]        gain_q;
  logic signed [40:0] tp_q;
  logic signed [23:0] cx_q;
  logic               cbig_q;
  logic [3:0]         ck_q;
  logic [27:0]        cprod_q;
  logic [31:0]        vnum_q;
  logic               out_valid_q;
  logic signed [23:0] sample_out_q;

  logic signed [23:0] mem_rd;
  logic signed [23:0] wb_val;
  logic signed [23:0] x_echo;
  logic signed [27:0] srnd;
  logic signed [18:0] sv_abs, sv;
  logic [18:0]        sv_off;
  logic [14:0]        lfo;
  logic [15:0]        lfo_inv;
  logic [22:0]        dnum_d;
  logic signed [23:0] x_trem;
  logic               xneg;
  logic [23:0]        ax;
  logic [15:0]        tdiff;
  logic [27:0]        cprod_d;
  logic [15:0]        ty;
  logic signed [23:0] x_clip;
  logic signed [32:0] vmul;
  logic [31:0]        div_num;
  logic [26:0]        div_quo;
  logic [26:0]        res_ext;

  atc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign echo_on = cfg.delay_len != '0;
  assign trem_on = cfg.depth != '0;
  assign depth_c = (cfg.depth > PCT_MAX) ? PCT_MAX : cfg.depth;
  assign vol_c   = (cfg.volume > PCT_MAX) ? PCT_MAX : cfg.volume;

  // Sequencer.
  assign in_stall_o = state_q != ST_IDLE;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_RD;
      ST_RD:   state_d = ST_MIX;
      ST_MIX:  state_d = ST_WB;
      ST_WB:   state_d = ST_TREM;
      ST_TREM: state_d = ST_CLIP;
      ST_CLIP: state_d = ST_VOL;
      ST_VOL:  state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Tremolo phase: steps once per item with tremolo on, after its use; APB writes clear it.
  always_comb begin
    phase_d = phase_q;
    if (cfg.wr) begin
      phase_d = '0;
    end else if (state_q == ST_RD && trem_on) begin
      phase_d = phase_q + PHASE_BITS'(PHASE_STEP);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Echo ring.
  atc_echo_store u_echo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_i       (cfg.clr),
    .delay_len_i (cfg.delay_len),
    .rd_en_i     (state_q == ST_RD && echo_on),
    .wr_en_i     (state_q == ST_WB && echo_on),
    .wr_data_i   (wb_val),
    .rd_data_o   (mem_rd)
  );

  // Sine lookup on the top 16 phase bits; odd quadrants run the table back.
  assign phase_w = {phase_q, 16'b0};
  assign p16     = phase_w[PHASE_BITS+15 -: 16];
  assign quad    = p16[15:14];
  assign seg     = p16[13:10];
  assign idx_a   = quad[0] ? (5'd16 - {1'b0, seg}) : {1'b0, seg};
  assign idx_b   = quad[0] ? (5'd15 - {1'b0, seg}) : ({1'b0, seg} + 5'd1);
  assign sa      = QSINE[idx_a];
  assign sb      = QSINE[idx_b];
  assign sdiff   = $signed({1'b0, sb}) - $signed({1'b0, sa});
  assign sprod_d = 28'(sdiff * $signed({1'b0, p16[9:0]}));

  // Oscillator value and the numerator of the depth scaling.
  assign srnd    = (sprod_q + 28'sd512) >>> 10;
  assign sv_abs  = $signed({3'b0, sa_q}) + 19'(srnd);
  assign sv      = sneg_q ? -sv_abs : sv_abs;
  assign sv_off  = 19'(sv + 19'sd32768);
  assign lfo     = sv_off[15:1];
  assign lfo_inv = 16'(17'd32768 - 17'(lfo));
  assign dnum_d  = 23'(depth_c * lfo_inv) + 23'd50;

  // Echo write back and wet mix.
  assign wb_val = sat24(32'(x_q) + q15_rnd(48'(fbp_q)));
  assign x_echo = echo_on ? sat24(32'(x_q) + q15_rnd(48'(wetp_q))) : x_q;

  // Tremolo result, then the soft clip lookup on its magnitude.
  assign x_trem  = trem_on ? sat24(q15_rnd(48'(tp_q))) : x_q;
  assign xneg    = x_trem[23];
  assign ax      = xneg ? 24'(-x_trem) : 24'(x_trem);
  assign tdiff   = TANH_TAB[{1'b0, ax[16:13]} + 5'd1] - TANH_TAB[{1'b0, ax[16:13]}];
  assign cprod_d = 28'(tdiff) * 28'(ax[12:0]);

  assign ty     = cbig_q ? TANH_TAB[16] :
                  16'(TANH_TAB[{1'b0, ck_q}] + 16'((cprod_q + 28'd4096) >> 13));
  assign x_clip = cfg.softclip ? (cx_q[23] ? -$signed({8'b0, ty}) : $signed({8'b0, ty}))
                               : cx_q;
  assign vmul   = x_clip * $signed({1'b0, vol_c});

  // The divide-by-100 unit serves the depth scaling and the master volume.
  assign div_num = (state_q == ST_OUT) ? vnum_q : 32'(dnum_q);

  atc_div100 u_div (
    .num_i (div_num),
    .quo_o (div_quo)
  );

  // Undo the volume offset: the biased quotient exceeds the result by 2^23.
  assign res_ext = div_quo - 27'd8388608;

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          x_q <= sample_in_i;
        end
      end
      ST_RD: begin
        sa_q    <= sa;
        sprod_q <= sprod_d;
        sneg_q  <= quad[1];
      end
      ST_MIX: begin
        fbp_q  <= mem_rd * FEEDBACK_Q15;
        wetp_q <= mem_rd * WET_Q15;
        dnum_q <= dnum_d;
      end
      ST_WB: begin
        x_q    <= x_echo;
        gain_q <= 16'(17'd32768 - 17'(div_quo));
      end
      ST_TREM: begin
        tp_q <= x_q * $signed({1'b0, gain_q});
      end
      ST_CLIP: begin
        cx_q    <= x_trem;
        cbig_q  <= ax[23:17] != '0;
        ck_q    <= ax[16:13];
        cprod_q <= cprod_d;
      end
      ST_VOL: begin
        vnum_q <= 32'(vmul) + 32'd50 + VOL_BIAS;
      end
      ST_OUT: begin
        if (out_free) begin
          sample_out_q <= res_ext[23:0];
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;

`include "audio_echo_tremolo_clip_chain_assert.svh"

  `ATC_ASSERT_NEXT(a_accept_starts_read, in_valid_i && !in_stall_o, state_q == ST_RD, "accepted item did not start with the ring read")
  `ATC_ASSERT_NOW(a_result_from_last_step, $rose(out_valid_q), $past(state_q) == ST_OUT, "result appeared outside the last step")
  `ATC_ASSERT_NEXT(a_held_result_blocks, state_q == ST_OUT && out_valid_q && out_stall_i, state_q == ST_OUT, "result overwritten while held")

endmodule

@@ dv/audio_echo_tremolo_clip_chain_test.sv @@
// Self-checking testbench for the audio echo, tremolo and soft-clip chain.
// Needs atc_pkg and the block's RTL; expected items come from the plan or its
// own fixed-point model of the chain, kept in step with every register write.
module audio_echo_tremolo_clip_chain_test import atc_pkg::*; ();

  localparam int RING_DEPTH     = 32768;
  localparam int ECHO_FB_GAIN   = 11469;
  localparam int ECHO_MIX_GAIN  = 18022;
  localparam int LFO_STEP       = ((5 << 16) + 11025) / 22050;
  localparam int SWEEP_ITEMS    = 560;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_ITEMS    = 48;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 24;
  localparam int REPORT_LIMIT   = 10;
  localparam int PLAN_ROWS      = 38;

  localparam int SINE_Q [0:16] = '{
    0, 3212, 6393, 9512, 12539, 15446, 18204, 20787, 23170,
    25329, 27245, 28898, 30273, 31356, 32137, 32609, 32767
  };

  localparam int TANH_Q [0:16] = '{
    0, 8026, 15143, 20813, 24956, 27797, 29660, 30847, 31589,
    32048, 32329, 32500, 32606, 32670, 32708, 32732, 32746
  };

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [1:0]         reg_idx;
    logic [31:0]        data;
    logic               known;
    logic signed [23:0] want;
  } plan_row_t;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic signed [23:0] sample_in_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [23:0] sample_out_o;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [CFG_AW-1:0]  paddr       = '0;
  logic [CFG_DW-1:0]  pwdata      = '0;
  logic [CFG_DW-1:0]  prdata;
  logic               pready;

  // Shadow state of the chain.
  logic signed [23:0] echo_ring [0:RING_DEPTH-1];
  int unsigned        ring_pos;
  logic [15:0]        lfo_phase;
  logic [15:0]        delay_len;
  logic [6:0]         trem_depth;
  logic               clip_en;
  logic [6:0]         master_vol;

  logic signed [23:0] expected_q [$];
  int send_idle_pct   = 0;
  int stall_pct       = 0;
  int errors          = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int reg_writes      = 0;
  int idle_cycles     = 0;

  // Items interleaved with settings that exercise the extremes and special cases.
  plan_row_t dir_plan [0:PLAN_ROWS-1] = '{
    '{ROW_SAMPLE, REG_DELAY,    32'h0000_0000, 1'b1,  24'sd0},
    '{ROW_SAMPLE, REG_DELAY,    32'h007F_FFFF, 1'b1,  24'sd6710886},
    '{ROW_SAMPLE, REG_DELAY,    32'h0080_0000, 1'b1, -24'sd6710886},
    '{ROW_SAMPLE, REG_DELAY,    32'h0000_0001, 1'b1,  24'sd1},
    '{ROW_SAMPLE, REG_DELAY,    32'h00FF_FFFF, 1'b1, -24'sd1},
    '{ROW_WRITE,  REG_VOLUME,   32'd100,       1'b0,  24'sd0},
    '{ROW_WRITE,  REG_SOFTCLIP, 32'd1,         1'b0,  24'sd0},
    '{ROW_SAMPLE, REG_DELAY,    32'h007F_FFFF, 1'b1,  24'sd32746},
    '{ROW_SAMPLE, REG_DELAY,    32'h0080_0000, 1'b1, -24'sd32746},
    '{ROW_SAMPLE, REG_DELAY,    32'h0000_0000, 1'b1,  24'sd0},
    '{ROW_SAMPLE, REG_DELAY,    32'd98304,     1'b0,  24'sd0},
    '{ROW_WRITE,  REG_SOFTCLIP, 32'd0,         1'b0,  24'sd0},
    '{ROW_WRITE,  REG_VOLUME,   32'd127,       1'b0,  24'sd0},
    '{ROW_SAMPLE, REG_DELAY,    32'h007F_FFFF, 1'b1,  24'sd8388607},
    '{ROW_WRITE,  REG_VOLUME,   32'd0,         1'b0,  24'sd0},
    '{ROW_SAMPLE, REG_DELAY,    32'h0080_0000, 1'b1,  24'sd0},
    '{ROW_WRITE,  REG_VOLUME,   32'd100,       1'b0,  24'sd0},
    '{ROW_WRITE,  REG_DELAY,    32'd1,         1'b0,  24'sd0},
    '{ROW_SAMPLE, REG_DELAY,    32'h007F_FFFF, 1'b1,  24'sd8388607},
    '{ROW_SAMPLE, REG_DELAY,    32'h007F_FFFF, 1'b1,  24'sd8388607},
    '{ROW_SAMPLE, REG_DELAY,    32'h0080_0000, 1'b0,  24'sd0},
    '{ROW_SAMPLE, REG_DELAY,    32'h0080_0000, 1'b0,  24'sd0},
    '{ROW_WRITE,  REG_DELAY,    32'd1,         1'b0,  24'sd0},
    '{ROW_SAMPLE, REG_DELAY,    32'd12345,     1'b0,  24'sd0},
    '{ROW_WRITE,  REG_DELAY,    32'd0,         1'b0,  24'sd0},
    '{ROW_SAMPLE, REG_DELAY,    32'd500,       1'b1,  24'sd500},
    '{ROW_WRITE,  REG_DELAY,    32'd3,         1'b0,  24'sd0},
    '{ROW_SAMPLE, REG_DELAY,    32'h0080_0000, 1'b1, -24'sd8388608},
    '{ROW_SAMPLE, REG_DELAY,    32'h0080_0000, 1'b1, -24'sd8388608},
    '{ROW_SAMPLE, REG_DELAY,    32'h0080_0000, 1'b1, -24'sd8388608},
    '{ROW_SAMPLE, REG_DELAY,    32'h0080_0000, 1'b1, -24'sd8388608},
    '{ROW_WRITE,  REG_DEPTH,    32'd100,       1'b0,  24'sd0},
    '{ROW_SAMPLE, REG_DELAY,    32'h0000_8000, 1'b0,  24'sd0},
    '{ROW_SAMPLE, REG_DELAY,    32'h00FF_8000, 1'b0,  24'sd0},
    '{ROW_WRITE,  REG_DEPTH,    32'd127,       1'b0,  24'sd0},
    '{ROW_SAMPLE, REG_DELAY,    32'h007F_FFFF, 1'b0,  24'sd0},
    '{ROW_WRITE,  REG_DELAY,    32'hFFFF_FFFF, 1'b0,  24'sd0},
    '{ROW_SAMPLE, REG_DELAY,    32'd4000,      1'b0,  24'sd0}
  };

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  audio_echo_tremolo_clip_chain u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_in_i (sample_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sample_out_o(sample_out_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  function automatic longint floor_div(input longint num, input longint den);
    if (num >= 0) begin
      return num / den;
    end
    return -((-num + den - 1) / den);
  endfunction

  function automatic longint clamp24(input longint v);
    if (v > 64'sd8388607) begin
      return 64'sd8388607;
    end
    if (v < -64'sd8388608) begin
      return -64'sd8388608;
    end
    return v;
  endfunction

  function automatic longint round_q15(input longint p);
    return floor_div(p + 16384, 32768);
  endfunction

  function automatic void note_error(input string what, input logic signed [63:0] want,
                                     input logic signed [63:0] got);
    errors++;
    if (errors <= REPORT_LIMIT) begin
      $display("Mismatch on %s: expected %0d, got %0d", what, want, got);
    end
  endfunction

  // Runs one item through echo, tremolo, soft clip and volume, and advances the
  // shadow state exactly as the block does.
  function automatic logic signed [23:0] predict_output(input logic signed [23:0] sample);
    longint     x, d, a, b, v, lfo, gain, pct, frac, ax, y;
    logic [1:0] quad;
    logic [3:0] seg;
    x = sample;
    if (delay_len != 0) begin
      if (ring_pos >= delay_len) begin
        ring_pos = 0;
      end
      d = echo_ring[ring_pos];
      echo_ring[ring_pos] = clamp24(x + round_q15(d * ECHO_FB_GAIN));
      x = clamp24(x + round_q15(d * ECHO_MIX_GAIN));
      ring_pos++;
      if (ring_pos >= delay_len) begin
        ring_pos = 0;
      end
    end
    if (trem_depth != 0) begin
      pct  = (trem_depth > 7'd100) ? 64'd100 : 64'(trem_depth);
      quad = lfo_phase[15:14];
      seg  = lfo_phase[13:10];
      frac = lfo_phase[9:0];
      // Odd quadrants walk the quarter wave backwards, the lower half is negated.
      if (quad[0]) begin
        a = SINE_Q[16 - seg];
        b = SINE_Q[15 - seg];
      end else begin
        a = SINE_Q[seg];
        b = SINE_Q[seg + 1];
      end
      v = a + floor_div((b - a) * frac + 512, 1024);
      if (quad[1]) begin
        v = -v;
      end
      lfo  = (v + 32768) / 2;
      gain = 32768 - floor_div(pct * (32768 - lfo) + 50, 100);
      x = clamp24(round_q15(x * gain));
      lfo_phase = lfo_phase + 16'(LFO_STEP);
    end
    if (clip_en) begin
      ax = (x < 0) ? -x : x;
      if (ax >= 131072) begin
        y = TANH_Q[16];
      end else begin
        seg  = ax[16:13];
        frac = ax[12:0];
        y = TANH_Q[seg] + floor_div((TANH_Q[seg + 1] - TANH_Q[seg]) * frac + 4096, 8192);
      end
      x = (x < 0) ? -y : y;
    end
    pct = (master_vol > 7'd100) ? 64'd100 : 64'(master_vol);
    x = clamp24(floor_div(x * pct + 50, 100));
    return x[23:0];
  endfunction

  function automatic void apply_register_write(input logic [1:0] idx, input logic [31:0] value);
    logic [15:0] len;
    len = value[15:0];
    case (idx)
      REG_DELAY: begin
        if (len > 16'(RING_DEPTH)) begin
          len = 16'(RING_DEPTH);
        end
        // Zero only turns the echo off; a new nonzero length restarts the ring.
        if (len == 0) begin
          delay_len = '0;
        end else if (len != delay_len) begin
          delay_len = len;
          ring_pos  = 0;
          foreach (echo_ring[i]) echo_ring[i] = '0;
        end
      end
      REG_DEPTH: begin
        trem_depth = value[6:0];
      end
      REG_SOFTCLIP: begin
        clip_en = value[0];
      end
      REG_VOLUME: begin
        master_vol = value[6:0];
      end
      default: ;
    endcase
    lfo_phase = '0;
  endfunction

  function automatic logic signed [23:0] random_sample();
    logic signed [23:0] v;
    v = 24'($urandom);
    case ($urandom_range(9))
      0: begin
        v = $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
      end
      1, 2, 3: begin
        // Around the soft-clip table, both signs.
        v = 24'($urandom_range(262143)) - 24'sd131072;
      end
      4: begin
        v = v >>> $urandom_range(23);
      end
      default: begin
      end
    endcase
    return v;
  endfunction

  // Writes a register, then reads it back over the same bus.
  task automatic program_register(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    apply_register_write(idx, value);
    reg_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_DELAY: begin
        if (prdata[15:0] !== delay_len) note_error("delay_length read", delay_len, prdata[15:0]);
      end
      REG_DEPTH: begin
        if (prdata[6:0] !== trem_depth) note_error("tremolo_depth read", trem_depth, prdata[6:0]);
      end
      REG_SOFTCLIP: begin
        if (prdata[0] !== clip_en) note_error("softclip_enable read", clip_en, prdata[0]);
      end
      REG_VOLUME: begin
        if (prdata[6:0] !== master_vol) note_error("volume read", master_vol, prdata[6:0]);
      end
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic feed_sample(input logic signed [23:0] value, input logic known,
                             input logic signed [23:0] want);
    logic signed [23:0] predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    predicted = predict_output(value);
    expected_q.push_back(known ? want : predicted);
    items_sent++;
  endtask

  // Holds the input back until every pending item has come out. The queue is
  // looked at on the falling edge so that the check never races the scoreboard.
  task automatic wait_for_results();
    if (expected_q.size() != 0) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while (expected_q.size() != 0);
      @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin : out_check
    logic signed [23:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("Output item %0d arrived with no item pending", sample_out_o);
        end
      end else begin
        want = expected_q.pop_front();
        results_checked++;
        if (sample_out_o !== want) begin
          note_error($sformatf("sample_out of item %0d", results_checked), want, sample_out_o);
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", idle_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t   row;
    logic [15:0] len;
    logic [6:0]  pct;
    foreach (echo_ring[i]) echo_ring[i] = '0;
    ring_pos   = 0;
    lfo_phase  = '0;
    delay_len  = '0;
    trem_depth = '0;
    clip_en    = 1'b0;
    master_vol = VOLUME_RESET;
    send_idle_pct = 25;
    stall_pct    <= 49;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_plan[i]) begin
      row = dir_plan[i];
      if (row.kind == ROW_WRITE) begin
        wait_for_results();
        program_register(row.reg_idx, row.data);
      end else begin
        feed_sample(row.data[23:0], row.known, row.want);
      end
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_for_results();
      case (phase * 3 / RANDOM_PHASES)
        0: begin
          send_idle_pct = 25;
          stall_pct    <= 49;
        end
        1: begin
          send_idle_pct = 49;
          stall_pct    <= 25;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct    <= 0;
        end
      endcase
      // Each register is rewritten about every other phase; the first writes all.
      if (phase == 0 || $urandom_range(1)) begin
        case ($urandom_range(7))
          0: len = '0;
          1: len = delay_len;
          2, 3: len = 16'($urandom_range(1, 8));
          4: len = 16'($urandom_range(9, 400));
          5: len = 16'($urandom_range(32768, 65535));
          default: len = 16'($urandom_range(1, 64));
        endcase
        program_register(REG_DELAY, {16'($urandom), len});
      end
      if (phase == 0 || $urandom_range(1)) begin
        case ($urandom_range(3))
          0: pct = 7'd0;
          1: pct = 7'd100;
          2: pct = 7'd127;
          default: pct = 7'($urandom_range(1, 127));
        endcase
        program_register(REG_DEPTH, {25'($urandom), pct});
      end
      if (phase == 0 || $urandom_range(1)) begin
        program_register(REG_SOFTCLIP, $urandom);
      end
      if (phase == 0 || $urandom_range(1)) begin
        case ($urandom_range(3))
          0: pct = 7'd0;
          1: pct = 7'd100;
          2: pct = 7'd127;
          default: pct = 7'($urandom_range(1, 127));
        endcase
        program_register(REG_VOLUME, {25'($urandom), pct});
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        feed_sample(random_sample(), 1'b0, '0);
        if ($urandom_range(63) == 0) begin
          wait_for_results();
        end
      end
    end

    // One uninterrupted tremolo run at full depth, so the oscillator walks many
    // segments of the sine table without a register write resetting it.
    wait_for_results();
    program_register(REG_DELAY, 32'd7);
    program_register(REG_SOFTCLIP, 32'($urandom_range(1)));
    program_register(REG_VOLUME, 32'd100);
    program_register(REG_DEPTH, 32'd100);
    for (int n = 0; n < SWEEP_ITEMS; n++) begin
      feed_sample(random_sample(), 1'b0, '0);
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d items: directed cases, %0d random phases and a long tremolo run,",
             items_sent, RANDOM_PHASES);
    $display("with %0d register writes; %0d results checked, %0d failures.",
             reg_writes, results_checked, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
